// File: hw/rtl/tmssc_pkg.sv
// ----------------------------------------------------------------------------
// tmssc_pkg
// Shared constants, types and helpers for the triggered multi-slot sample
// capture block: slot ring geometry, action codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tmssc_pkg;

  // slot ring geometry
  localparam int SLOT_COUNT    = 8;
  localparam int SLOT_LENGTH   = 4096;
  localparam int CHANNEL_COUNT = 2;
  localparam int SAMPLE_BITS   = 24;

  localparam int STORE_DEPTH = SLOT_COUNT * SLOT_LENGTH * CHANNEL_COUNT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LEN_W       = $clog2(SLOT_LENGTH + 2);
  localparam int ACC_W       = SAMPLE_BITS + $clog2(SLOT_COUNT + 1) + 1;

  localparam logic [LEN_W-1:0]  LEN_FULL  = LEN_W'(SLOT_LENGTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

  // port widths fixed by the interface
  localparam int ACTION_W   = 3;
  localparam int CHOICE_W   = 3;
  localparam int NCH_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = CFG_IDX_W'(1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_FRAME  = 3'd0,
    ACT_PLAY   = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_SELECT = 3'd3,
    ACT_ARM    = 3'd4,
    ACT_DISARM = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RECW,
    ST_SCAN,
    ST_ADD0,
    ST_ADD1,
    ST_DONE
  } state_t;

  // sample store access from the sequencer
  typedef struct packed {
    logic              we;
    logic              re;
    logic              ch;
    logic [ADDR_W-1:0] addr;
  } mem_ctl_t;

  // accumulate strobe toward the mixer
  typedef struct packed {
    logic add;
    logic ch;
  } mix_ctl_t;

  // flat store address of one sample
  function automatic logic [ADDR_W-1:0] store_addr(logic [SLOT_W-1:0] slot,
                                                   logic [LEN_W-1:0] pos,
                                                   logic ch);
    int a;
    a = (int'(slot) * SLOT_LENGTH + int'(pos)) * CHANNEL_COUNT + int'(ch);
    return ADDR_W'(a);
  endfunction

  // channel count register clamped to the supported range
  function automatic logic [NCH_W-1:0] chans_in_use(logic [NCH_W-1:0] a);
    logic [NCH_W-1:0] r;
    r = a;
    if (a == '0) begin
      r = NCH_W'(1);
    end else if (int'(a) > CHANNEL_COUNT) begin
      r = NCH_W'(CHANNEL_COUNT);
    end
    return r;
  endfunction

  // next slot of the ring
  function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    r = s + SLOT_W'(1);
    if (s == SLOT_LAST) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tmssc_store.sv
// ----------------------------------------------------------------------------
// tmssc_store
// Single-port sample memory: one write or one read per cycle, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tmssc_store (
  input  wire logic                             clk,
  input  wire tmssc_pkg::mem_ctl_t              ctl,
  input  wire logic [tmssc_pkg::SAMPLE_BITS-1:0] wdata,
  output logic      [tmssc_pkg::SAMPLE_BITS-1:0] rdata
);

  logic [tmssc_pkg::SAMPLE_BITS-1:0] mem [tmssc_pkg::STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.addr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[ctl.addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tmssc_mix.sv
// ----------------------------------------------------------------------------
// tmssc_mix
// Per-channel accumulators with one shared adder. Loaded with the dry frame
// on a frame request (cleared on any other request), then summed with stored samples and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module tmssc_mix (
  input  wire logic                              clk,
  input  wire logic                              load,
  input  wire logic [tmssc_pkg::ACTION_W-1:0]    action,
  input  wire logic [tmssc_pkg::SAMPLE_BITS-1:0] sample_left,
  input  wire logic [tmssc_pkg::SAMPLE_BITS-1:0] sample_right,
  input  wire logic [tmssc_pkg::NCH_W-1:0]       nch,
  input  wire tmssc_pkg::mix_ctl_t               ctl,
  input  wire logic [tmssc_pkg::SAMPLE_BITS-1:0] rdata,
  input  wire logic                              wr_ch,
  output logic      [tmssc_pkg::SAMPLE_BITS-1:0] wdata,
  output logic                                   dry_nz,
  output logic      [tmssc_pkg::SAMPLE_BITS-1:0] sat_left,
  output logic      [tmssc_pkg::SAMPLE_BITS-1:0] sat_right
);

  localparam int SB  = tmssc_pkg::SAMPLE_BITS;
  localparam int AW  = tmssc_pkg::ACC_W;
  localparam int EXT = AW - SB;

  logic [AW-1:0] acc [2];
  logic [AW-1:0] acc_sel;
  logic [AW-1:0] sum;
  logic          is_frame;

  assign is_frame = (tmssc_pkg::action_t'(action) == tmssc_pkg::ACT_FRAME);

  // shared adder
  assign acc_sel = acc[ctl.ch];
  assign sum     = acc_sel + {{EXT{rdata[SB-1]}}, rdata};

  // accumulator load and update
  always_ff @(posedge clk) begin
    if (load) begin
      acc[0] <= is_frame ? {{EXT{sample_left[SB-1]}}, sample_left} : '0;
      acc[1] <= (is_frame && nch >= tmssc_pkg::NCH_W'(2))
                ? {{EXT{sample_right[SB-1]}}, sample_right} : '0;
    end else if (ctl.add) begin
      acc[ctl.ch] <= sum;
    end
  end

  // dry values still sit in the accumulators before any playback add
  assign wdata  = acc[wr_ch][SB-1:0];
  assign dry_nz = (acc[0] != '0) || (acc[1] != '0);

  // saturation to the sample range
  function automatic logic [SB-1:0] sat(logic [AW-1:0] v);
    logic [SB-1:0] r;
    r = v[SB-1:0];
    if (v[AW-1:SB-1] != '0 && v[AW-1:SB-1] != '1) begin
      r = v[AW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end
    return r;
  endfunction

  assign sat_left  = sat(acc[0]);
  assign sat_right = sat(acc[1]);

endmodule

`default_nettype wire

// File: hw/rtl/tmssc_seq.sv
// ----------------------------------------------------------------------------
// tmssc_seq
// Sequencer and slot state: executes one request, writes the take sample,
// then walks the slot ring issuing one store read per channel of each playing slot.
// ----------------------------------------------------------------------------
`default_nettype none

module tmssc_seq (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_accept,
  input  wire logic [tmssc_pkg::ACTION_W-1:0] in_action,
  input  wire logic [tmssc_pkg::CHOICE_W-1:0] in_choice,
  input  wire logic                           enabled,
  input  wire logic [tmssc_pkg::NCH_W-1:0]    nch,
  input  wire logic                           dry_nz,
  input  wire logic                           out_free,
  output logic                                busy,
  output logic                                out_load,
  output tmssc_pkg::mem_ctl_t                 mem_ctl,
  output tmssc_pkg::mix_ctl_t                 mix_ctl,
  output logic                                recording,
  output logic                                armed,
  output logic      [tmssc_pkg::SLOT_W-1:0]   cur_slot
);

  localparam int SW = tmssc_pkg::SLOT_W;
  localparam int LW = tmssc_pkg::LEN_W;
  localparam int NS = tmssc_pkg::SLOT_COUNT;

  tmssc_pkg::state_t  state, state_next;
  tmssc_pkg::action_t act;
  logic [tmssc_pkg::CHOICE_W-1:0] choice;

  logic [LW-1:0] take_len [NS];
  logic [LW-1:0] play_pos [NS];
  logic [NS-1:0] play_on;

  logic [SW-1:0] scan_slot;
  logic [LW-1:0] scan_pos;
  logic [SW-1:0] rec_slot;
  logic [LW-1:0] rec_pos;

  // take length read port
  logic [SW-1:0] tl_idx;
  logic [LW-1:0] tl_rd;

  // record step terms
  logic          rec_start;
  logic          rec_on;
  logic [LW-1:0] rec_p;
  logic [LW-1:0] rec_len1;
  logic          rec_full;
  logic          rec_wr;

  // playback step terms
  logic [LW-1:0] sp;
  logic [LW-1:0] sp1;
  logic          hit;
  logic          scan_last;

  assign tl_idx = (state == tmssc_pkg::ST_SCAN) ? scan_slot : cur_slot;
  assign tl_rd  = take_len[tl_idx];

  assign rec_start = armed && !recording && dry_nz;
  assign rec_on    = recording || rec_start;
  assign rec_p     = rec_start ? '0 : tl_rd;
  assign rec_len1  = rec_p + LW'(1);
  assign rec_full  = (rec_len1 >= tmssc_pkg::LEN_FULL);
  assign rec_wr    = (rec_p < tmssc_pkg::LEN_FULL);

  assign sp        = play_pos[scan_slot];
  assign sp1       = sp + LW'(1);
  assign hit       = play_on[scan_slot] && (sp < tl_rd) && (sp < tmssc_pkg::LEN_FULL);
  assign scan_last = (scan_slot == tmssc_pkg::SLOT_LAST);

  assign busy = (state != tmssc_pkg::ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmssc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    mem_ctl    = '0;
    mix_ctl    = '0;
    out_load   = 1'b0;
    unique case (state)
      tmssc_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = tmssc_pkg::ST_EXEC;
        end
      end
      tmssc_pkg::ST_EXEC: begin
        state_next = tmssc_pkg::ST_DONE;
        if (act == tmssc_pkg::ACT_FRAME && enabled) begin
          state_next = tmssc_pkg::ST_SCAN;
          if (armed && rec_on && rec_wr) begin
            mem_ctl.we   = 1'b1;
            mem_ctl.ch   = 1'b0;
            mem_ctl.addr = tmssc_pkg::store_addr(cur_slot, rec_p, 1'b0);
            if (tmssc_pkg::CHANNEL_COUNT > 1) begin
              state_next = tmssc_pkg::ST_RECW;
            end
          end
        end
      end
      tmssc_pkg::ST_RECW: begin
        mem_ctl.we   = 1'b1;
        mem_ctl.ch   = 1'b1;
        mem_ctl.addr = tmssc_pkg::store_addr(rec_slot, rec_pos, 1'b1);
        state_next   = tmssc_pkg::ST_SCAN;
      end
      tmssc_pkg::ST_SCAN: begin
        if (hit) begin
          mem_ctl.re   = 1'b1;
          mem_ctl.addr = tmssc_pkg::store_addr(scan_slot, sp, 1'b0);
          state_next   = tmssc_pkg::ST_ADD0;
        end else if (scan_last) begin
          state_next = tmssc_pkg::ST_DONE;
        end
      end
      tmssc_pkg::ST_ADD0: begin
        mix_ctl.add = 1'b1;
        mix_ctl.ch  = 1'b0;
        if (tmssc_pkg::CHANNEL_COUNT > 1) begin
          mem_ctl.re   = 1'b1;
          mem_ctl.ch   = 1'b1;
          mem_ctl.addr = tmssc_pkg::store_addr(scan_slot, scan_pos, 1'b1);
          state_next   = tmssc_pkg::ST_ADD1;
        end else begin
          state_next = scan_last ? tmssc_pkg::ST_DONE : tmssc_pkg::ST_SCAN;
        end
      end
      tmssc_pkg::ST_ADD1: begin
        mix_ctl.add = (nch >= tmssc_pkg::NCH_W'(2));
        mix_ctl.ch  = 1'b1;
        state_next  = scan_last ? tmssc_pkg::ST_DONE : tmssc_pkg::ST_SCAN;
      end
      tmssc_pkg::ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = tmssc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tmssc_pkg::ST_IDLE;
      end
    endcase
  end

  // request latch
  always_ff @(posedge clk) begin
    if (in_accept) begin
      act    <= tmssc_pkg::action_t'(in_action);
      choice <= in_choice;
    end
  end

  // slot state, flags and scan registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        take_len[i] <= '0;
        play_pos[i] <= '0;
      end
      play_on   <= '0;
      recording <= 1'b0;
      armed     <= 1'b0;
      cur_slot  <= '0;
      scan_slot <= '0;
      scan_pos  <= '0;
      rec_slot  <= '0;
      rec_pos   <= '0;
    end else begin
      case (state)
        tmssc_pkg::ST_EXEC: begin
          scan_slot <= '0;
          unique case (act)
            tmssc_pkg::ACT_FRAME: begin
              if (enabled) begin
                if (armed) begin
                  if (rec_on) begin
                    rec_slot <= cur_slot;
                    rec_pos  <= rec_p;
                    if (rec_full) begin
                      take_len[cur_slot] <= tmssc_pkg::LEN_FULL;
                      recording          <= 1'b0;
                      armed              <= 1'b0;
                      cur_slot           <= tmssc_pkg::next_slot(cur_slot);
                    end else begin
                      take_len[cur_slot] <= rec_len1;
                      recording          <= 1'b1;
                    end
                  end
                end else if (recording) begin
                  // take ends on the first frame after a disarm
                  recording <= 1'b0;
                  cur_slot  <= tmssc_pkg::next_slot(cur_slot);
                end
              end
            end
            tmssc_pkg::ACT_PLAY: begin
              play_on[cur_slot]  <= 1'b1;
              play_pos[cur_slot] <= '0;
            end
            tmssc_pkg::ACT_DELETE: begin
              take_len[cur_slot] <= '0;
            end
            tmssc_pkg::ACT_SELECT: begin
              if (!recording && int'(choice) < NS) begin
                cur_slot <= SW'(choice);
              end
            end
            tmssc_pkg::ACT_ARM: begin
              armed <= 1'b1;
            end
            tmssc_pkg::ACT_DISARM: begin
              armed <= 1'b0;
            end
            default: begin
            end
          endcase
        end
        tmssc_pkg::ST_SCAN: begin
          if (play_on[scan_slot]) begin
            scan_pos <= sp;
            if (sp1 >= tl_rd) begin
              play_on[scan_slot]  <= 1'b0;
              play_pos[scan_slot] <= '0;
            end else begin
              play_pos[scan_slot] <= sp1;
            end
          end
          if (!hit) begin
            scan_slot <= scan_slot + SW'(1);
          end
        end
        tmssc_pkg::ST_ADD0: begin
          if (tmssc_pkg::CHANNEL_COUNT == 1) begin
            scan_slot <= scan_slot + SW'(1);
          end
        end
        tmssc_pkg::ST_ADD1: begin
          scan_slot <= scan_slot + SW'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/triggered_multi_slot_sample_capture.sv
// ----------------------------------------------------------------------------
// triggered_multi_slot_sample_capture
// Ring of capture slots fed by audio frames and control requests: armed
// recording on the first nonzero sample, playback mixed onto the dry input.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ------------------------------------------
//   in        in_valid / in_stall    action, sample_left, sample_right,
//                                    slot_choice
//   out       out_valid / out_stall  mix_left, mix_right, is_recording,
//                                    is_armed, slot_now
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A control request passes from EXEC straight to DONE; an enabled frame passes
// through EXEC, RECW if a take sample is written, then SCAN for each slot with
// nothing to add and SCAN, ADD0 and ADD1 for each slot that adds a stored
// frame, then DONE. The single sample store port sets this: one write or one
// read per cycle. Reset is synchronous and clears all slot lengths, play
// state and flags; the store itself is not cleared.
// in_stall is high from accept until the result is loaded into the output
// register; a stalled result waits there while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module triggered_multi_slot_sample_capture (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // request channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [tmssc_pkg::ACTION_W-1:0]       action,
  input  wire logic [tmssc_pkg::SAMPLE_BITS-1:0]    sample_left,
  input  wire logic [tmssc_pkg::SAMPLE_BITS-1:0]    sample_right,
  input  wire logic [tmssc_pkg::CHOICE_W-1:0]       slot_choice,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic      [tmssc_pkg::SAMPLE_BITS-1:0]    mix_left,
  output logic      [tmssc_pkg::SAMPLE_BITS-1:0]    mix_right,
  output logic                                      is_recording,
  output logic                                      is_armed,
  output logic      [tmssc_pkg::CHOICE_W-1:0]       slot_now,
  // configuration write channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [tmssc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tmssc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                              enabled;
  logic [tmssc_pkg::NCH_W-1:0]       active_channels;
  logic [tmssc_pkg::NCH_W-1:0]       nch;
  logic                              in_accept;
  logic                              out_free;
  logic                              busy;
  logic                              out_load;
  logic                              dry_nz;
  logic                              recording;
  logic                              armed;
  logic [tmssc_pkg::SLOT_W-1:0]      cur_slot;
  logic [tmssc_pkg::SAMPLE_BITS-1:0] wdata;
  logic [tmssc_pkg::SAMPLE_BITS-1:0] rdata;
  logic [tmssc_pkg::SAMPLE_BITS-1:0] sat_left;
  logic [tmssc_pkg::SAMPLE_BITS-1:0] sat_right;
  tmssc_pkg::mem_ctl_t               mem_ctl;
  tmssc_pkg::mix_ctl_t               mix_ctl;

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;
  assign out_free  = !out_valid || !out_stall;
  assign nch       = tmssc_pkg::chans_in_use(active_channels);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled         <= 1'b1;
      active_channels <= tmssc_pkg::NCH_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tmssc_pkg::REG_ENABLED:  enabled         <= cfg_data[0];
        tmssc_pkg::REG_CHANNELS: active_channels <= cfg_data[tmssc_pkg::NCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tmssc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_action (action),
    .in_choice (slot_choice),
    .enabled   (enabled),
    .nch       (nch),
    .dry_nz    (dry_nz),
    .out_free  (out_free),
    .busy      (busy),
    .out_load  (out_load),
    .mem_ctl   (mem_ctl),
    .mix_ctl   (mix_ctl),
    .recording (recording),
    .armed     (armed),
    .cur_slot  (cur_slot)
  );

  tmssc_mix u_mix (
    .clk          (clk),
    .load         (in_accept),
    .action       (action),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .nch          (nch),
    .ctl          (mix_ctl),
    .rdata        (rdata),
    .wr_ch        (mem_ctl.ch),
    .wdata        (wdata),
    .dry_nz       (dry_nz),
    .sat_left     (sat_left),
    .sat_right    (sat_right)
  );

  tmssc_store u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .wdata (wdata),
    .rdata (rdata)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      mix_left     <= sat_left;
      mix_right    <= sat_right;
      is_recording <= recording;
      is_armed     <= armed;
      slot_now     <= tmssc_pkg::CHOICE_W'(cur_slot);
    end
  end

endmodule

`default_nettype wire
